// ----- design/stg_pkg.sv -----
// ----------------------------------------------------------------------------
// stg_pkg
// Shared types and constants of the square tone generator.
// ----------------------------------------------------------------------------
package stg_pkg;

   localparam int CHANNELS       = 8;
   localparam int COUNTER_WIDTH  = 16;
   localparam int HALF_WIDTH     = 15;
   localparam int BUDGET_WIDTH   = 32;
   localparam int PRESCALE_WIDTH = 16;
   localparam int OUT_LANES      = 8;
   localparam int DIV_WIDTH      = 32;
   localparam int DIVISOR_WIDTH  = 16;
   localparam int STEP_WIDTH     = $clog2(DIV_WIDTH);
   localparam int SCALED_WIDTH   = 2 * DIV_WIDTH;
   localparam int RECIP_SHIFT    = 41;
   localparam int APB_DATA_WIDTH = 32;
   localparam int APB_ADDR_WIDTH = 2;

   localparam logic [PRESCALE_WIDTH-1:0] PRESCALE_RESET = 16'd59;
   localparam logic [DIV_WIDTH-1:0]      TICK_RATE      = 32'd1000000;
   localparam logic [15:0]               FREQ_MIN       = 16'd20;
   localparam logic [15:0]               FREQ_MAX       = 16'd20000;
   // ceil(2^41 / 1000): exact floor division by 1000 for dividends below 2^32
   localparam logic [DIV_WIDTH-1:0]      MS_RECIP       = 32'd2199023256;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [2:0]  channel;
      logic [15:0] frequency;
      logic [15:0] duration_ms;
   } req_type;

   typedef struct packed {
      logic [7:0] levels;
      logic [7:0] active_mask;
      logic       rejected;
   } rsp_type;

   typedef struct packed {
      logic tick;
      logic stop;
      logic load;
      logic half_done;
      logic commit;
      logic reject;
      logic push;
   } cmd_type;

   typedef struct packed {
      logic freq_ok;
      logic chan_ok;
      logic div_done;
   } status_type;

endpackage

// ----- design/square_tone_generator.sv -----
// ----------------------------------------------------------------------------
// square_tone_generator
// Multi-channel square-wave tone generator with a shared microsecond timebase.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command beat: a timer tick, a start tone, a stop tone or a no-op.
//   rsp_* returns one beat per command: channel levels, running mask and a
//   reject flag for a start whose frequency lies outside 20..20000 Hz.
//   The APB port holds the prescale register (timer clocks per us, minus one).
// Sequencing:
//   Ticks, stops, no-ops and rejected starts are registered into the result
//   queue on acceptance, and such beats may follow every cycle while req_stall is low.
//   A valid start holds req_stall through 32 steps of the one-bit-per-cycle
//   half period divider, a handoff state and a commit state that pushes its
//   result beat; no new beat is taken before the commit.
//   The toggle budget is formed meanwhile by a reciprocal multiply.
// Stalls:
//   A two-beat result queue absorbs rsp_stall; req_stall rises only when the
//   queue is full or a start is being computed.
// Reset:
//   All channels stop with level low, the timebase clears, prescale returns
//   to 59 and the result queue empties.
// ----------------------------------------------------------------------------
module square_tone_generator
   import stg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [APB_ADDR_WIDTH-1:0] paddr,
   input  logic [APB_DATA_WIDTH-1:0] pwdata,
   output logic [APB_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   logic [PRESCALE_WIDTH-1:0] prescale_ff, prescale_in;
   logic                      csr_write;
   cmd_type                   cmd;
   status_type                status;
   rsp_type                   rsp_next;
   logic                      queue_full;

   // single register: every address decodes to prescale
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr == paddr);
   assign prdata    = APB_DATA_WIDTH'(prescale_ff);

   always_comb begin
      prescale_in = prescale_ff;
      if (csr_write) begin
         prescale_in = pwdata[PRESCALE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= PRESCALE_RESET;
      end else begin
         prescale_ff <= prescale_in;
      end
   end

   stg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_op     (req_data.op),
      .status     (status),
      .queue_full (queue_full),
      .req_stall  (req_stall),
      .cmd        (cmd)
   );

   stg_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req      (req_data),
      .prescale (prescale_ff),
      .status   (status),
      .rsp_next (rsp_next)
   );

   stg_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd.push),
      .push_data (rsp_next),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- design/stg_divider.sv -----
// ----------------------------------------------------------------------------
// stg_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stg_divider
   import stg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIV_WIDTH-1:0]     dividend,
   input  logic [DIVISOR_WIDTH-1:0] divisor,
   output logic                     done,
   output logic [DIV_WIDTH-1:0]     quotient
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [STEP_WIDTH-1:0]    step_ff, step_in;
   logic [DIV_WIDTH-1:0]     work_ff, work_in;
   logic [DIVISOR_WIDTH-1:0] rem_ff, rem_in;
   logic [DIVISOR_WIDTH-1:0] divisor_ff, divisor_in;
   logic [DIVISOR_WIDTH:0]   trial;
   logic [DIVISOR_WIDTH:0]   diff;
   logic                     fits;

   always_comb begin
      trial      = {rem_ff, work_ff[DIV_WIDTH-1]};
      diff       = trial - {1'b0, divisor_ff};
      fits       = trial >= {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         work_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         work_in = {work_ff[DIV_WIDTH-2:0], fits};
         rem_in  = fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_WIDTH'(DIV_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

// ----- design/stg_datapath.sv -----
// ----------------------------------------------------------------------------
// stg_datapath
// Timebase, per-channel compare state and start arithmetic.
// ----------------------------------------------------------------------------
module stg_datapath
   import stg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   input  req_type                   req,
   input  logic [PRESCALE_WIDTH-1:0] prescale,
   output status_type                status,
   output rsp_type                   rsp_next
);

   logic [PRESCALE_WIDTH-1:0] presc_cnt_ff, presc_cnt_in;
   logic [COUNTER_WIDTH-1:0]  counter_ff, counter_in;
   logic [COUNTER_WIDTH-1:0]  counter_step;
   logic                      wrap;

   logic [HALF_WIDTH-1:0]     half_period_ff [CHANNELS];
   logic [HALF_WIDTH-1:0]     half_period_in [CHANNELS];
   logic [COUNTER_WIDTH-1:0]  compare_ff     [CHANNELS];
   logic [COUNTER_WIDTH-1:0]  compare_in     [CHANNELS];
   logic [BUDGET_WIDTH-1:0]   toggles_ff     [CHANNELS];
   logic [BUDGET_WIDTH-1:0]   toggles_in     [CHANNELS];
   logic [CHANNELS-1:0]       forever_ff, forever_in;
   logic [CHANNELS-1:0]       running_ff, running_in;
   logic [CHANNELS-1:0]       level_ff, level_in;

   logic [CHANNELS-1:0]       chan_sel_ff, chan_sel_in;
   logic [DIVISOR_WIDTH-1:0]  two_f;
   logic [DIVISOR_WIDTH-1:0]  two_f_ff;
   logic [15:0]               dur_ff;
   logic [HALF_WIDTH-1:0]     half_ff;
   logic [DIV_WIDTH-1:0]      product_ff;
   logic [SCALED_WIDTH-1:0]   scaled;
   logic [BUDGET_WIDTH-1:0]   budget_ff;

   logic                      div_start;
   logic [DIV_WIDTH-1:0]      div_dividend;
   logic [DIVISOR_WIDTH-1:0]  div_divisor;
   logic                      div_done;
   logic [DIV_WIDTH-1:0]      div_quotient;

   // frequency is at most 20000 on any accepted start, so 2f fits 16 bits
   assign two_f = {req.frequency[14:0], 1'b0};

   assign div_start    = cmd.load;
   assign div_dividend = TICK_RATE;
   assign div_divisor  = two_f;

   stg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign status.freq_ok  = (req.frequency >= FREQ_MIN) && (req.frequency <= FREQ_MAX);
   assign status.chan_ok  = int'(req.channel) < CHANNELS;
   assign status.div_done = div_done;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         chan_sel_in[c] = int'(req.channel) == c;
      end
   end

   always_comb begin
      wrap         = presc_cnt_ff >= prescale;
      counter_step = counter_ff + 1'b1;
      presc_cnt_in = presc_cnt_ff;
      counter_in   = counter_ff;
      if (cmd.tick) begin
         if (wrap) begin
            presc_cnt_in = '0;
            counter_in   = counter_step;
         end else begin
            presc_cnt_in = presc_cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         half_period_in[c] = half_period_ff[c];
         compare_in[c]     = compare_ff[c];
         toggles_in[c]     = toggles_ff[c];
         forever_in[c]     = forever_ff[c];
         running_in[c]     = running_ff[c];
         level_in[c]       = level_ff[c];
         priority if (cmd.tick && wrap && running_ff[c] && compare_ff[c] == counter_step) begin
            level_in[c]   = ~level_ff[c];
            compare_in[c] = compare_ff[c] + COUNTER_WIDTH'(half_period_ff[c]);
            if (!forever_ff[c]) begin
               if (toggles_ff[c] != '0) begin
                  toggles_in[c] = toggles_ff[c] - 1'b1;
               end else begin
                  running_in[c]     = 1'b0;
                  forever_in[c]     = 1'b0;
                  half_period_in[c] = '0;
                  toggles_in[c]     = '0;
                  level_in[c]       = 1'b0;
               end
            end
         end else if (cmd.stop && chan_sel_in[c]) begin
            running_in[c]     = 1'b0;
            forever_in[c]     = 1'b0;
            half_period_in[c] = '0;
            toggles_in[c]     = '0;
            level_in[c]       = 1'b0;
         end else if (cmd.commit && chan_sel_ff[c]) begin
            half_period_in[c] = half_ff;
            compare_in[c]     = counter_ff + COUNTER_WIDTH'(half_ff);
            level_in[c]       = 1'b0;
            running_in[c]     = 1'b1;
            forever_in[c]     = dur_ff == '0;
            toggles_in[c]     = (dur_ff == '0) ? '0 : budget_ff;
         end else begin
            level_in[c] = level_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         presc_cnt_ff <= '0;
         counter_ff   <= '0;
         forever_ff   <= '0;
         running_ff   <= '0;
         level_ff     <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            half_period_ff[c] <= '0;
            compare_ff[c]     <= '0;
            toggles_ff[c]     <= '0;
         end
      end else begin
         presc_cnt_ff <= presc_cnt_in;
         counter_ff   <= counter_in;
         forever_ff   <= forever_in;
         running_ff   <= running_in;
         level_ff     <= level_in;
         for (int c = 0; c < CHANNELS; c++) begin
            half_period_ff[c] <= half_period_in[c];
            compare_ff[c]     <= compare_in[c];
            toggles_ff[c]     <= toggles_in[c];
         end
      end
   end

   // budget = floor(2f * d / 1000) by reciprocal multiply, registered in product_ff then budget_ff
   assign scaled = SCALED_WIDTH'(product_ff) * SCALED_WIDTH'(MS_RECIP);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         chan_sel_ff <= chan_sel_in;
         two_f_ff    <= two_f;
         dur_ff      <= req.duration_ms;
      end
      if (cmd.half_done) begin
         half_ff <= div_quotient[HALF_WIDTH-1:0];
      end
      product_ff <= DIV_WIDTH'(two_f_ff) * DIV_WIDTH'(dur_ff);
      budget_ff  <= BUDGET_WIDTH'(scaled[SCALED_WIDTH-1:RECIP_SHIFT]);
   end

   for (genvar i = 0; i < OUT_LANES; i++) begin : g_lane
      if (i < CHANNELS) begin : g_used
         assign rsp_next.levels[i]      = level_in[i];
         assign rsp_next.active_mask[i] = running_in[i];
      end else begin : g_unused
         assign rsp_next.levels[i]      = 1'b0;
         assign rsp_next.active_mask[i] = 1'b0;
      end
   end

   assign rsp_next.rejected = cmd.reject;

endmodule

// ----- design/stg_ctrl.sv -----
// ----------------------------------------------------------------------------
// stg_ctrl
// Sequencer: accepts items and steps a start through the half-period division.
// ----------------------------------------------------------------------------
module stg_ctrl
   import stg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  op_type     req_op,
   input  status_type status,
   input  logic       queue_full,
   output logic       req_stall,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_HALF   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      ready;

   assign ready     = (state_ff == ST_IDLE) && !queue_full;
   assign req_stall = !ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ready && req_valid) begin
               unique case (req_op)
                  OP_TICK: begin
                     cmd.tick = 1'b1;
                     cmd.push = 1'b1;
                  end
                  OP_START: begin
                     priority if (!status.freq_ok) begin
                        cmd.reject = 1'b1;
                        cmd.push   = 1'b1;
                     end else if (!status.chan_ok) begin
                        cmd.push = 1'b1;
                     end else begin
                        cmd.load = 1'b1;
                        state_in = ST_HALF;
                     end
                  end
                  OP_STOP: begin
                     cmd.stop = 1'b1;
                     cmd.push = 1'b1;
                  end
                  OP_NONE: begin
                     cmd.push = 1'b1;
                  end
               endcase
            end
         end
         ST_HALF: begin
            if (status.div_done) begin
               cmd.half_done = 1'b1;
               state_in      = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            cmd.push   = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/stg_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// stg_rsp_queue
// Two-beat result queue between the datapath and the result channel.
// ----------------------------------------------------------------------------
module stg_rsp_queue
   import stg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign rsp_valid = count_ff != 2'd0;
   assign full      = count_ff == 2'd2;
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- test/square_tone_generator_test.sv -----
// ----------------------------------------------------------------------------
// square_tone_generator_test
// Self-checking bench for the multi-channel square tone generator. A short
// table of commands covers rejected frequencies, the unused op code, start,
// restart, stop, the prescale rollover and a tone that runs out of budget.
// Random phases follow at several prescale settings and idle/stall mixes.
// Each result beat is compared with its table entry or a cycle-free tone model kept here.
// ----------------------------------------------------------------------------
module square_tone_generator_test;
   import stg_pkg::*;

   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int DRAIN_CYCLES    = 80;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int MAX_REPORTS     = 10;
   localparam logic [APB_ADDR_WIDTH-1:0] PRESCALE_ADDR = '0;

   typedef struct {
      bit          set_prescale;
      logic [15:0] prescale_value;
      req_type     item;
      int          repeats;
      bit          typed;
      rsp_type     want;
   } stim_row;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [APB_ADDR_WIDTH-1:0] paddr = '0;
   logic [APB_DATA_WIDTH-1:0] pwdata = '0;
   logic [APB_DATA_WIDTH-1:0] prdata;
   logic pready;

   // tone model state
   logic [15:0] prescale_q = PRESCALE_RESET;
   logic [15:0] tick_count = '0;
   logic [15:0] us_count = '0;
   logic [14:0] half_q [CHANNELS] = '{default: '0};
   logic [15:0] compare_q [CHANNELS] = '{default: '0};
   logic [31:0] budget_q [CHANNELS] = '{default: '0};
   bit [CHANNELS-1:0] endless_q = '0;
   bit [CHANNELS-1:0] running_q = '0;
   bit [CHANNELS-1:0] level_q = '0;

   rsp_type expected_status [$];
   stim_row stim_table [$];
   int mismatches = 0;
   int quiet_cycles = 0;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_off_requests = 0;
   int hold_off_served = 0;
   int hold_left = 0;

   square_tone_generator dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      if (mismatches < MAX_REPORTS) begin
         $display("mismatch %s: expected %h, got %h", what, want, got);
      end
      mismatches++;
   endtask

   function automatic void halt_tone(int c);
      running_q[c] = 1'b0;
      endless_q[c] = 1'b0;
      half_q[c] = '0;
      budget_q[c] = '0;
      level_q[c] = 1'b0;
   endfunction

   function automatic rsp_type next_status(req_type item);
      rsp_type s;
      int c;
      s = '0;
      case (item.op)
         OP_TICK: begin
            if (tick_count >= prescale_q) begin
               tick_count = '0;
               us_count = us_count + 16'd1;
               for (c = 0; c < CHANNELS; c++) begin
                  if (running_q[c] && compare_q[c] == us_count) begin
                     level_q[c] = !level_q[c];
                     compare_q[c] = compare_q[c] + 16'(half_q[c]);
                     if (!endless_q[c]) begin
                        if (budget_q[c] != 0) budget_q[c] = budget_q[c] - 1;
                        else halt_tone(c);
                     end
                  end
               end
            end else begin
               tick_count = tick_count + 16'd1;
            end
         end
         OP_START: begin
            if (item.frequency < FREQ_MIN || item.frequency > FREQ_MAX) begin
               s.rejected = 1'b1;
            end else begin
               c = int'(item.channel);
               half_q[c] = 15'(TICK_RATE / (32'd2 * 32'(item.frequency)));
               compare_q[c] = us_count + 16'(half_q[c]);
               level_q[c] = 1'b0;
               running_q[c] = 1'b1;
               if (item.duration_ms == 0) begin
                  endless_q[c] = 1'b1;
                  budget_q[c] = '0;
               end else begin
                  endless_q[c] = 1'b0;
                  budget_q[c] = 32'((64'd2 * 64'(item.frequency) * 64'(item.duration_ms))
                                    / 64'd1000);
               end
            end
         end
         OP_STOP: halt_tone(int'(item.channel));
         default: ;
      endcase
      for (c = 0; c < CHANNELS && c < OUT_LANES; c++) begin
         s.levels[c] = level_q[c];
         s.active_mask[c] = running_q[c];
      end
      return s;
   endfunction

   task automatic send_beat(req_type item, bit typed, rsp_type want);
      rsp_type predicted;
      @(negedge clock);
      while (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do begin
         @(posedge clock);
      end while (req_stall);
      predicted = next_status(item);
      expected_status.push_back(typed ? want : predicted);
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
   endtask

   task automatic write_prescale(logic [15:0] value);
      drain();
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= PRESCALE_ADDR;
      pwdata <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== 32'(value)) report_mismatch("prescale readback", 32'(value), prdata);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      prescale_q = value;
   endtask

   task automatic add_item(op_type op, int ch, int f, int d, int repeats = 1,
                           bit typed = 1'b0, logic [7:0] lv = '0, logic [7:0] act = '0,
                           bit rej = 1'b0);
      stim_row row;
      row.set_prescale = 1'b0;
      row.prescale_value = '0;
      row.item.op = op;
      row.item.channel = 3'(ch);
      row.item.frequency = 16'(f);
      row.item.duration_ms = 16'(d);
      row.repeats = repeats;
      row.typed = typed;
      row.want.levels = lv;
      row.want.active_mask = act;
      row.want.rejected = rej;
      stim_table.push_back(row);
   endtask

   function automatic req_type random_command(bit narrow);
      req_type item;
      int unsigned roll;
      int unsigned pick;
      item.channel = 3'($urandom);
      item.frequency = 16'($urandom);
      item.duration_ms = 16'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < (narrow ? 95 : 88)) begin
         item.op = OP_TICK;
      end else if (roll < (narrow ? 98 : 95)) begin
         item.op = OP_START;
         pick = $urandom_range(0, 9);
         if (pick < 6) item.frequency = 16'($urandom_range(2000, 20000));
         else if (pick < 8) item.frequency = 16'($urandom_range(20, 1999));
         pick = $urandom_range(0, 9);
         if (pick < 5) item.duration_ms = 16'($urandom_range(1, 4));
         else if (pick < 7) item.duration_ms = '0;
      end else if (roll < 99) begin
         item.op = OP_STOP;
      end else begin
         item.op = OP_NONE;
      end
      if (narrow) item.channel[2] = 1'b0;
      return item;
   endfunction

   task automatic run_phase(logic [15:0] prescale, int idle_pct, int stall_pct, int items,
                            bit narrow, bit pressure);
      req_type item;
      int c;
      write_prescale(prescale);
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      if (pressure) hold_off_requests++;
      // short-budget tones on the upper channels so they run out
      for (c = 4; c < CHANNELS; c++) begin
         item.op = OP_START;
         item.channel = 3'(c);
         item.frequency = 16'($urandom_range(19231, 19499));
         item.duration_ms = 16'd1;
         send_beat(item, 1'b0, '0);
      end
      repeat (items) send_beat(random_command(narrow), 1'b0, '0);
   endtask

   // receiver side: random stall plus one long hold-off per request
   always @(negedge clock) begin
      if (hold_off_served != hold_off_requests) begin
         hold_left = HOLD_OFF_CYCLES;
         hold_off_served++;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status.size() == 0) begin
            report_mismatch("unexpected beat", '0, 32'(rsp_data));
         end else begin
            want = expected_status.pop_front();
            if (rsp_data.levels !== want.levels)
               report_mismatch("levels", 32'(want.levels), 32'(rsp_data.levels));
            if (rsp_data.active_mask !== want.active_mask)
               report_mismatch("active_mask", 32'(want.active_mask),
                               32'(rsp_data.active_mask));
            if (rsp_data.rejected !== want.rejected)
               report_mismatch("rejected", 32'(want.rejected), 32'(rsp_data.rejected));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("square_tone_generator_test NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      stim_row row;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_item(OP_TICK, 0, 0, 0, 1, 1'b1, 8'h00, 8'h00, 1'b0);
      add_item(OP_START, 0, 19, 100, 1, 1'b1, 8'h00, 8'h00, 1'b1);
      add_item(OP_START, 1, 20001, 100, 1, 1'b1, 8'h00, 8'h00, 1'b1);
      add_item(OP_START, 2, 0, 0, 1, 1'b1, 8'h00, 8'h00, 1'b1);
      add_item(OP_START, 3, 65535, 65535, 1, 1'b1, 8'h00, 8'h00, 1'b1);
      add_item(OP_NONE, 7, 65535, 65535, 1, 1'b1, 8'h00, 8'h00, 1'b0);
      add_item(OP_START, 7, 20000, 0, 1, 1'b1, 8'h00, 8'h80, 1'b0);
      add_item(OP_START, 0, 20, 65535, 1, 1'b1, 8'h00, 8'h81, 1'b0);
      add_item(OP_STOP, 7, 0, 0, 1, 1'b1, 8'h00, 8'h01, 1'b0);
      add_item(OP_TICK, 5, 65535, 65535, 59);
      add_item(OP_TICK, 0, 0, 0);
      add_item(OP_START, 0, 20, 1);
      add_item(OP_STOP, 5, 0, 0);
      add_item(OP_STOP, 0, 0, 0, 1, 1'b1, 8'h00, 8'h00, 1'b0);
      row.set_prescale = 1'b1;
      row.prescale_value = 16'd0;
      row.repeats = 0;
      stim_table.push_back(row);
      add_item(OP_START, 2, 20000, 1);
      add_item(OP_START, 5, 20000, 0);
      add_item(OP_START, 6, 19999, 2);
      add_item(OP_TICK, 0, 0, 0, 1100);
      add_item(OP_STOP, 5, 0, 0);
      add_item(OP_STOP, 6, 0, 0);

      foreach (stim_table[i]) begin
         if (stim_table[i].set_prescale) write_prescale(stim_table[i].prescale_value);
         repeat (stim_table[i].repeats)
            send_beat(stim_table[i].item, stim_table[i].typed, stim_table[i].want);
      end

      run_phase(16'd0, 0, 0, 300, 1'b1, 1'b0);
      run_phase(16'd1, 58, 0, 100, 1'b0, 1'b0);
      run_phase(16'd0, 0, 58, 100, 1'b0, 1'b1);
      run_phase(16'd65535, 30, 30, 50, 1'b0, 1'b0);
      run_phase(16'd2, 30, 30, 100, 1'b0, 1'b0);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_status.size() == 0) begin
         $display("square_tone_generator_test OK");
      end else begin
         $display("square_tone_generator_test NOT OK");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/stg_pkg.sv
design/stg_divider.sv
design/stg_datapath.sv
design/stg_ctrl.sv
design/stg_rsp_queue.sv
design/square_tone_generator.sv
test/square_tone_generator_test.sv
